>>> rtl/core/b64d_pkg.sv
// shared types and constants of the streaming base64 decoder
`timescale 1ns / 1ps

package b64d_pkg;

	// input transaction: one character of the encoded text
	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} b64d_in_t;

	// output transaction: one decoded byte
	typedef struct packed {
		logic [7:0] data_byte;
		logic       run_end;
		logic       stream_end;
		logic [1:0] status;
	} b64d_out_t;

	// status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_BAD   = 2'd1;
	localparam logic [1:0] STAT_TRUNC = 2'd2;

	// special characters of the alphabet
	localparam logic [7:0] CH_PAD   = 8'h3D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	// one finished group, handed from the front to the back
	typedef struct packed {
		logic [23:0] triple;     // three bytes, first byte highest
		logic [1:0]  count;      // bytes to emit, 1 to 3
		logic        last;       // group closes the stream
		logic [1:0]  status;
	} b64d_grp_t;

	localparam int QUEUE_DEPTH = 4;

endpackage

>>> rtl/core/b64d_front.sv
// front end: takes characters, maps them to sextets and builds groups
`timescale 1ns / 1ps

module b64d_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	output logic                char_stall,
	input  b64d_pkg::b64d_in_t  char_data,
	output logic                push,
	output b64d_pkg::b64d_grp_t push_grp,
	input  logic                queue_full
);
	import b64d_pkg::*;

	typedef struct packed {
		logic [5:0] sextet;
		logic       pad;
		logic       bad;
	} b64d_cls_t;

	function automatic b64d_cls_t classify(input logic [7:0] ch);
		b64d_cls_t r;
		begin
			r = '0;
			priority if (ch >= 8'h41 && ch <= 8'h5A) begin
				r.sextet = 6'(ch - 8'h41);
			end else if (ch >= 8'h61 && ch <= 8'h7A) begin
				r.sextet = 6'(ch - 8'h47);
			end else if (ch >= 8'h30 && ch <= 8'h39) begin
				r.sextet = 6'(ch + 8'h04);
			end else if (ch == CH_PLUS) begin
				r.sextet = 6'd62;
			end else if (ch == CH_SLASH) begin
				r.sextet = 6'd63;
			end else if (ch == CH_PAD) begin
				r.pad = 1'b1;
			end else begin
				r.bad = 1'b1;
			end
			return r;
		end
	endfunction

	logic [17:0] acc_q;
	logic [1:0]  pos_q;
	logic        tpad_q;
	logic        bad_q;

	b64d_cls_t cls;
	logic      accept;
	logic      bad_n;
	logic      last;
	logic [1:0] trim;

	assign char_stall = queue_full;
	assign accept     = char_valid && !char_stall;
	assign cls        = classify(char_data.char_code);
	assign last       = char_data.last_char;
	assign bad_n      = bad_q | cls.bad;
	assign trim       = {1'b0, cls.pad} + {1'b0, tpad_q};

	always_comb begin
		push     = 1'b0;
		push_grp = '0;
		if (accept) begin
			if (pos_q == 2'd3) begin
				push            = 1'b1;
				push_grp.triple = {acc_q, cls.sextet};
				push_grp.count  = last ? 2'(2'd3 - trim) : 2'd3;
				push_grp.last   = last;
				push_grp.status = bad_n ? STAT_BAD : STAT_OK;
			end else if (last) begin
				// stream cut mid-group
				push            = 1'b1;
				push_grp.count  = 2'd1;
				push_grp.last   = 1'b1;
				push_grp.status = STAT_TRUNC;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pos_q  <= '0;
			tpad_q <= 1'b0;
			bad_q  <= 1'b0;
		end else if (accept) begin
			if (pos_q == 2'd3 || last) begin
				acc_q  <= '0;
				pos_q  <= '0;
				tpad_q <= 1'b0;
				bad_q  <= 1'b0;
			end else begin
				acc_q  <= {acc_q[11:0], cls.sextet};
				pos_q  <= pos_q + 2'd1;
				tpad_q <= tpad_q | (pos_q == 2'd2 && cls.pad);
				bad_q  <= bad_n;
			end
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> pos_q == 2'd0 && !tpad_q && !bad_q)
		else $error("group state not cleared after final character");

	a_trunc_shape: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_grp.status == STAT_TRUNC |-> push_grp.count == 2'd1 &&
		push_grp.triple == 24'd0 && push_grp.last)
		else $error("truncation entry malformed");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> push_grp.count != 2'd0)
		else $error("group pushed with no bytes");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && queue_full))
		else $error("group pushed into full queue");

endmodule

>>> rtl/core/b64d_queue.sv
// short group queue between front and back
`timescale 1ns / 1ps

module b64d_queue #(
	parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  b64d_pkg::b64d_grp_t push_grp,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output b64d_pkg::b64d_grp_t head_grp
);
	import b64d_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	b64d_grp_t     mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full       = cnt_q == FULL_CNT;
	assign head_valid = cnt_q != '0;
	assign head_grp   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/core/b64d_back.sv
// back end: splits queued groups into bytes behind an output register
`timescale 1ns / 1ps

module b64d_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  b64d_pkg::b64d_grp_t head_grp,
	output logic                pop,
	output logic                byte_valid,
	input  logic                byte_stall,
	output b64d_pkg::b64d_out_t byte_data
);
	import b64d_pkg::*;

	logic [1:0] idx_q;
	logic       byte_valid_q;
	b64d_out_t  byte_q;

	logic       load;
	logic       final_byte;
	logic [7:0] sel_byte;

	assign load       = !byte_valid_q || !byte_stall;
	assign final_byte = (idx_q + 2'd1) == head_grp.count;
	assign pop        = load && head_valid && final_byte;

	always_comb begin
		unique case (idx_q)
			2'd0:    sel_byte = head_grp.triple[23:16];
			2'd1:    sel_byte = head_grp.triple[15:8];
			default: sel_byte = head_grp.triple[7:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q.data_byte  <= sel_byte;
			byte_q.run_end    <= final_byte;
			byte_q.stream_end <= final_byte && head_grp.last;
			byte_q.status     <= head_grp.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			byte_valid_q <= 1'b0;
		end else if (load) begin
			byte_valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= final_byte ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	assign byte_valid = byte_valid_q;
	assign byte_data  = byte_q;

endmodule

>>> rtl/core/base64_stream_decoder_core.sv
// top level of the streaming base64 decoder
`timescale 1ns / 1ps
// throughput: one character and one decoded byte per cycle, unless that side stalls
// first byte of a group: registered in the group queue, then in the output register
// a group drains byte by byte; the group queue absorbs the 4:3 rate mismatch
// reset: arst_n asynchronously clears group state, queue pointers and output valid

module base64_stream_decoder_core #(
	parameter int QDEPTH = b64d_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	// character channel
	input  logic                char_valid,
	output logic                char_stall,
	input  b64d_pkg::b64d_in_t  char_data,
	// byte channel
	output logic                byte_valid,
	input  logic                byte_stall,
	output b64d_pkg::b64d_out_t byte_data
);
	import b64d_pkg::*;

	// front to queue
	logic      push;
	b64d_grp_t push_grp;
	logic      queue_full;

	// queue to back
	logic      pop;
	logic      head_valid;
	b64d_grp_t head_grp;

	// front: sextet mapping, group assembly, truncation detect
	b64d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.push       (push),
		.push_grp   (push_grp),
		.queue_full (queue_full)
	);

	// queue of finished groups, lets the two sides stall independently
	b64d_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_grp   (push_grp),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_grp   (head_grp)
	);

	// back: one byte per transaction through the output register
	b64d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_grp   (head_grp),
		.pop        (pop),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data)
	);

endmodule
